FILE: sv/double_ended_queue_unit_assert.svh
// Assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DEQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DEQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/deq_pkg.sv
// Types and constants of the double-ended queue unit
package deq_pkg;

    typedef enum logic [2:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_PEEK_FRONT = 3'd4,
        K_PEEK_BACK  = 3'd5,
        K_CLEAR      = 3'd6
    } deq_kind_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] push_value;
    } deq_in_t;

    typedef struct packed {
        logic [31:0] out_value;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } deq_out_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } deq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic needs_read;
    } deq_stat_t;

endpackage

FILE: sv/double_ended_queue_unit.sv
// Top level of the double-ended queue unit
// A deque of up to DEPTH words of WIDTH bits in a single-port ring store. Every
// transaction on s_ carries one operation and returns one result on m_ with the
// word removed or peeked, a status and the entry count after the operation. A
// push, clear, no-op or empty/full case passes from acceptance through the exec
// state back to idle; a pop or peek also passes a read state, the registered
// read of the ring store. Execution waits while the previous result is still
// held in the output register, so a stalled m_ready holds it back.
// No clearing pass after reset: the store is only read at slots that hold entries.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_in_t  s_in,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_out_t m_out
);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_in    (s_in),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_out   (m_out)
    );

endmodule

FILE: sv/deq_ctrl.sv
// Sequencing state machine of the double-ended queue unit
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  deq_stat_t stat,
    output deq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        cmd.latch  = ready_reg && s_valid;
        cmd.exec   = (state_reg == S_EXEC) && stat.out_free;
        cmd.load   = (state_reg == S_READ);
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.latch) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.out_free) state_next = stat.needs_read ? S_READ : S_IDLE;
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

FILE: sv/deq_datapath.sv
// Ring store, head/count registers and result register of the deque
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  deq_in_t   s_in,
    input  deq_cmd_t  cmd,
    output deq_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output deq_out_t  m_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    deq_in_t          op_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    deq_out_t         out_reg;

    logic [1:0]       status_v;
    logic             wr_v, rd_v;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [IDX_W-1:0] slot_front, slot_tail, slot_second, slot_last;
    logic             is_full, is_empty;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] h,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = {1'b0, h} + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign is_empty    = (count_reg == '0);
    assign slot_front  = wrap(head_reg, CNT_W'(DEPTH - 1));
    assign slot_tail   = wrap(head_reg, count_reg);
    assign slot_second = wrap(head_reg, CNT_W'(1));
    assign slot_last   = wrap(head_reg, count_reg - 1'b1);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        status_v   = ST_OK;
        wr_v       = 1'b0;
        rd_v       = 1'b0;
        wr_addr    = slot_tail;
        rd_addr    = head_reg;
        unique case (op_reg.kind) inside
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (is_full) begin
                    status_v = ST_FULL;
                end else begin
                    wr_v       = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (op_reg.kind == K_PUSH_FRONT) begin
                        head_next = slot_front;
                        wr_addr   = slot_front;
                    end
                end
            end
            K_POP_FRONT, K_PEEK_FRONT: begin
                if (is_empty) begin
                    status_v = ST_EMPTY;
                end else begin
                    rd_v = 1'b1;
                    if (op_reg.kind == K_POP_FRONT) begin
                        head_next  = slot_second;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            K_POP_BACK, K_PEEK_BACK: begin
                if (is_empty) begin
                    status_v = ST_EMPTY;
                end else begin
                    rd_v    = 1'b1;
                    rd_addr = slot_last;
                    if (op_reg.kind == K_POP_BACK) count_next = count_reg - 1'b1;
                end
            end
            K_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            default: ;
        endcase
    end

    assign stat.out_free   = !out_valid_reg || m_ready;
    assign stat.needs_read = rd_v;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if ((cmd.exec && !rd_v) || cmd.load) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cmd.exec) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) op_reg <= s_in;
        if (cmd.exec) begin
            out_reg.out_value   <= '0;
            out_reg.status      <= status_v;
            out_reg.entry_count <= 5'(count_next);
        end
        if (cmd.load) out_reg.out_value <= 32'(rd_data_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_v) mem[wr_addr] <= WIDTH'(op_reg.push_value);
        if (cmd.exec && rd_v) rd_data_reg <= mem[rd_addr];
    end

    assign m_valid = out_valid_reg;
    assign m_out   = out_reg;

endmodule

FILE: sv/deq_checker.sv
// Port-level assertions of the double-ended queue unit and their bind
`include "double_ended_queue_unit_assert.svh"

module deq_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input deq_out_t m_out
);

    `DEQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out), "result changed while stalled")
    `DEQ_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_out.status != 2'd3, "undefined status code")
    `DEQ_ASSERT_NOW(a_full_count, aclk, aresetn, m_valid && m_out.status == ST_FULL, m_out.entry_count == 5'(DEPTH) && m_out.out_value == '0, "full status with wrong count or value")
    `DEQ_ASSERT_NOW(a_empty_count, aclk, aresetn, m_valid && m_out.status == ST_EMPTY, m_out.entry_count == '0 && m_out.out_value == '0, "empty status with nonzero count or value")
    `DEQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "accepted back to back")

endmodule

bind double_ended_queue_unit deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_out   (m_out)
);

FILE: bench/double_ended_queue_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the double-ended queue unit: mirrors the deque and compares every result
module double_ended_queue_unit_checker
    import deq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  deq_in_t  s_in,
    input  logic     m_valid,
    input  logic     m_ready,
    input  deq_out_t m_out,
    output int       fail_count,
    output int       pending,
    output int       checked,
    output int       full_hits,
    output int       empty_hits
);

    localparam int DEPTH = 16;

    logic [31:0] ring [DEPTH];
    logic [3:0]  head;
    logic [4:0]  fill;
    deq_out_t    owed_results [$];

    // applies one operation to the mirror deque and returns its result
    function automatic deq_out_t deque_apply(deq_in_t op);
        deq_out_t   res;
        logic [3:0] slot;
        res = '0;
        res.status = ST_OK;
        case (op.kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    res.status = ST_FULL;
                end else if (op.kind == K_PUSH_FRONT) begin
                    head = head - 4'd1;
                    ring[head] = op.push_value;
                    fill = fill + 5'd1;
                end else begin
                    slot = head + fill[3:0];
                    ring[slot] = op.push_value;
                    fill = fill + 5'd1;
                end
            end
            K_POP_FRONT, K_PEEK_FRONT: begin
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_value = ring[head];
                    if (op.kind == K_POP_FRONT) begin
                        head = head + 4'd1;
                        fill = fill - 5'd1;
                    end
                end
            end
            K_POP_BACK, K_PEEK_BACK: begin
                if (fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = head + fill[3:0] - 4'd1;
                    res.out_value = ring[slot];
                    if (op.kind == K_POP_BACK) begin
                        fill = fill - 5'd1;
                    end
                end
            end
            K_CLEAR: begin
                head = '0;
                fill = '0;
            end
            default: begin
            end
        endcase
        res.entry_count = fill;
        return res;
    endfunction

    always @(posedge aclk) begin
        deq_out_t want;
        if (!aresetn) begin
            head = '0;
            fill = '0;
            owed_results.delete();
        end else begin
            // result side first: a result never belongs to a transaction accepted this edge
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: out_value %h status %0d entry_count %0d",
                           m_out.out_value, m_out.status, m_out.entry_count);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    checked++;
                    if (m_out.out_value !== want.out_value) begin
                        $error("out_value: expected %h, actual %h",
                               want.out_value, m_out.out_value);
                        fail_count++;
                    end
                    if (m_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_out.status);
                        fail_count++;
                    end
                    if (m_out.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, m_out.entry_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = deque_apply(s_in);
                if (want.status == ST_FULL) full_hits++;
                if (want.status == ST_EMPTY) empty_hits++;
                owed_results.push_back(want);
            end
        end
        pending = owed_results.size();
    end

endmodule

FILE: bench/double_ended_queue_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the double-ended queue unit: stimulus, handshake idling and verdict
module double_ended_queue_unit_test;
    import deq_pkg::*;

    localparam logic [2:0] KIND_UNUSED  = 3'd7;
    localparam int         RANDOM_ITEMS = 1680;
    localparam int         QUIET_ITEMS  = 250;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    deq_in_t  s_in    = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    deq_out_t m_out;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int empty_hits;
    int sent;
    bit quiet;

    always #4 aclk = ~aclk;

    double_ended_queue_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_in    (s_in),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_out   (m_out)
    );

    double_ended_queue_unit_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in       (s_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out      (m_out),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_hits  (full_hits),
        .empty_hits (empty_hits)
    );

    // one transaction on s_, with an occasional idle burst ahead of it
    task automatic send_op(input logic [2:0] kind, input logic [31:0] word);
        deq_in_t op;
        op.kind = kind;
        op.push_value = word;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // mode 0 leans to pushes, 1 to pops, 2 is balanced
    function automatic logic [2:0] pick_kind(int mode);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        push_pct = (mode == 0) ? 75 : (mode == 1) ? 15 : 45;
        pop_pct  = (mode == 0) ? 15 : (mode == 1) ? 70 : 35;
        if (r < 1) return KIND_UNUSED;
        if (r < 3) return K_CLEAR;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? K_PUSH_BACK : K_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? K_POP_BACK : K_POP_FRONT;
        return $urandom_range(0, 1) ? K_PEEK_BACK : K_PEEK_FRONT;
    endfunction

    // result side stalls in bursts
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    initial begin
        int mode;
        int run_left;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty reads, extreme words at both ends, unused code, clear
        send_op(K_POP_FRONT, 32'h0);
        send_op(K_POP_BACK, 32'hFFFF_FFFF);
        send_op(K_PEEK_FRONT, 32'h0);
        send_op(K_PEEK_BACK, 32'h0);
        send_op(K_PUSH_BACK, 32'h0000_0000);
        send_op(K_PUSH_BACK, 32'hFFFF_FFFF);
        send_op(K_PUSH_FRONT, 32'h8000_0001);
        send_op(K_PUSH_FRONT, 32'h7FFF_FFFE);
        send_op(K_PEEK_FRONT, 32'h0);
        send_op(K_PEEK_BACK, 32'h0);
        send_op(KIND_UNUSED, 32'hDEAD_BEEF);
        send_op(K_POP_BACK, 32'h0);
        send_op(K_POP_FRONT, 32'h0);
        send_op(K_POP_FRONT, 32'h0);
        send_op(K_POP_BACK, 32'h0);
        send_op(K_POP_FRONT, 32'h0);
        send_op(K_PUSH_BACK, 32'hA5A5_5A5A);
        send_op(K_PUSH_FRONT, 32'h0000_0001);
        send_op(K_CLEAR, 32'hFFFF_FFFF);
        send_op(K_PEEK_BACK, 32'h0);
        send_op(K_PUSH_FRONT, 32'h5555_AAAA);
        send_op(K_POP_BACK, 32'h0);

        run_left = 0;
        mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
            if (run_left == 0) begin
                mode = (mode == 0) ? $urandom_range(1, 2) : $urandom_range(0, 2);
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            send_op(pick_kind(mode), pick_word());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d transactions sent, %0d results checked", sent, checked);
        $display("%0d pushes hit a full queue, %0d reads hit an empty one",
                 full_hits, empty_hits);
        if (fail_count == 0) begin
            $display("double_ended_queue_unit: match");
        end else begin
            $display("double_ended_queue_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("double_ended_queue_unit: mismatch");
        $finish;
    end

endmodule
